// File: src/mspfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspfp_pkg
// Shared types and constants of the MSP V1/V2 frame parser.
// ----------------------------------------------------------------------------
package mspfp_pkg;

  // CRC8 DVB-S2 generator polynomial
  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  // Framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24; // '$'
  localparam logic [7:0] CH_M      = 8'h4D; // 'M'
  localparam logic [7:0] CH_X      = 8'h58; // 'X'
  localparam logic [7:0] CH_LT     = 8'h3C; // '<'
  localparam logic [7:0] CH_GT     = 8'h3E; // '>'

  localparam logic [7:0] TUNNEL_CMD_RESET = 8'hFF;
  localparam logic [7:0] TUNNEL_HDR_BYTES = 8'd6; // inner header plus inner CRC

  // Result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_V1_CHK_BAD = 3'd1;
  localparam logic [2:0] ST_V2_CRC_BAD = 3'd2;
  localparam logic [2:0] ST_TUN_CRC_BAD = 3'd3;
  localparam logic [2:0] ST_TUN_LEN_BAD = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_V1DIR,
    PH_V1SIZE,
    PH_V1CMD,
    PH_V1PAY,
    PH_V1CHK,
    PH_V2DIR,
    PH_V2FLG,
    PH_V2IDL,
    PH_V2IDH,
    PH_V2LENL,
    PH_V2LENH,
    PH_V2PAY,
    PH_V2CRC
  } phase_t;

endpackage

// File: src/mspfp_crc8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspfp_crc8
// One-byte CRC8 DVB-S2 update, MSB first, unrolled into XOR logic.
// ----------------------------------------------------------------------------
module mspfp_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] v;
    v = crc_in ^ data_in;
    for (int i = 0; i < 8; i++) begin
      if ((v & mspfp_pkg::CRC_MSB) != 8'd0) begin
        v = {v[6:0], 1'b0} ^ mspfp_pkg::CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    crc_out = v;
  end

endmodule

// File: src/msp_v1_v2_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_v1_v2_frame_parser_unit
// MSP V1/V2 serial frame parser with V2-over-V1 tunnel support.
// ----------------------------------------------------------------------------
// One serial byte is taken per word on the input channel, one byte per clock
// when the output side keeps up: the parse state and the CRC8 byte update
// sit between the state registers and a single output register, so a new
// byte is accepted in the same cycle the previous result is taken. Payload
// bytes come out as they arrive (kind 0); the closing byte of each frame
// gives a verdict word (kind 1) with status, version, tunnel flag, command
// id, flags and payload length, so the consumer drops rejected frames after
// the fact. Header bytes that do not fit resynchronize silently to idle.
// tunnel_command (reset 0xFF) is written through the cfg channel; the user
// must write it only while the parser is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module msp_v1_v2_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic [2:0]  out_status,
  output logic        out_frame_version,
  output logic        out_is_tunneled,
  output logic [15:0] out_command_id,
  output logic [7:0]  out_frame_flags,
  output logic [15:0] out_payload_length
);

  // config register
  logic [7:0] tunnel_cmd_r;

  // parse state
  mspfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  outer_size_r, outer_size_nxt;
  logic [15:0] byte_index_r, byte_index_nxt;
  logic [15:0] command_r, command_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] inner_len_r, inner_len_nxt;
  logic [7:0]  xor_sum_r, xor_sum_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        tunnel_r, tunnel_nxt;
  logic        len_bad_r, len_bad_nxt;

  // result being formed this cycle
  logic        emit;
  logic        res_kind;
  logic [7:0]  res_data;
  logic [2:0]  res_status;
  logic        res_ver;
  logic        res_tun;
  logic [15:0] res_len;

  // output register
  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_data_r;
  logic [2:0]  out_status_r;
  logic        out_ver_r;
  logic        out_tun_r;
  logic [15:0] out_cmd_r;
  logic [7:0]  out_flags_r;
  logic [15:0] out_len_r;

  logic       in_fire;
  logic [7:0] crc_step;
  logic       is_dir;
  logic [16:0] idx_plus1;
  logic [16:0] inner_plus6;

  assign cfg_ready = 1'b1;
  // output register frees up when empty or being drained this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  mspfp_crc8 u_crc (
    .crc_in  (crc_r),
    .data_in (in_byte),
    .crc_out (crc_step)
  );

  assign is_dir      = (in_byte == mspfp_pkg::CH_LT) || (in_byte == mspfp_pkg::CH_GT);
  assign idx_plus1   = {1'b0, byte_index_r} + 17'd1;
  // inner length plus inner header and CRC, as it stands once the high byte arrives
  assign inner_plus6 = {1'b0, in_byte, inner_len_r[7:0]} +
                       {9'd0, mspfp_pkg::TUNNEL_HDR_BYTES};

  // next-state: parse phase and frame context
  always_comb begin
    phase_nxt      = phase_r;
    outer_size_nxt = outer_size_r;
    byte_index_nxt = byte_index_r;
    command_nxt    = command_r;
    flags_nxt      = flags_r;
    inner_len_nxt  = inner_len_r;
    xor_sum_nxt    = xor_sum_r;
    crc_nxt        = crc_r;
    tunnel_nxt     = tunnel_r;
    len_bad_nxt    = len_bad_r;
    case (phase_r)
      mspfp_pkg::PH_IDLE: begin
        if (in_byte == mspfp_pkg::CH_DOLLAR) phase_nxt = mspfp_pkg::PH_START;
      end
      mspfp_pkg::PH_START: begin
        if (in_byte == mspfp_pkg::CH_M)      phase_nxt = mspfp_pkg::PH_V1DIR;
        else if (in_byte == mspfp_pkg::CH_X) phase_nxt = mspfp_pkg::PH_V2DIR;
        else                                 phase_nxt = mspfp_pkg::PH_IDLE;
      end
      mspfp_pkg::PH_V1DIR: begin
        phase_nxt = is_dir ? mspfp_pkg::PH_V1SIZE : mspfp_pkg::PH_IDLE;
      end
      mspfp_pkg::PH_V1SIZE: begin
        outer_size_nxt = in_byte;
        xor_sum_nxt    = in_byte;
        phase_nxt      = mspfp_pkg::PH_V1CMD;
      end
      mspfp_pkg::PH_V1CMD: begin
        command_nxt    = {8'd0, in_byte};
        flags_nxt      = 8'd0;
        xor_sum_nxt    = xor_sum_r ^ in_byte;
        crc_nxt        = 8'd0;
        byte_index_nxt = 16'd0;
        len_bad_nxt    = 1'b0;
        inner_len_nxt  = 16'd0;
        tunnel_nxt     = (in_byte == tunnel_cmd_r) &&
                         (outer_size_r >= mspfp_pkg::TUNNEL_HDR_BYTES);
        phase_nxt      = (outer_size_r == 8'd0) ? mspfp_pkg::PH_V1CHK
                                                : mspfp_pkg::PH_V1PAY;
      end
      mspfp_pkg::PH_V1PAY: begin
        xor_sum_nxt = xor_sum_r ^ in_byte;
        if (tunnel_r) begin
          crc_nxt = crc_step;
          case (byte_index_r)
            16'd0: flags_nxt = in_byte;
            16'd1: command_nxt = {8'd0, in_byte};
            16'd2: command_nxt = {in_byte, command_r[7:0]};
            16'd3: inner_len_nxt = {8'd0, in_byte};
            16'd4: begin
              inner_len_nxt = {in_byte, inner_len_r[7:0]};
              len_bad_nxt   = ({9'd0, outer_size_r} != inner_plus6);
            end
            default: ;
          endcase
        end
        byte_index_nxt = idx_plus1[15:0];
        if (idx_plus1 >= {9'd0, outer_size_r}) phase_nxt = mspfp_pkg::PH_V1CHK;
      end
      mspfp_pkg::PH_V1CHK: begin
        phase_nxt = mspfp_pkg::PH_IDLE;
      end
      mspfp_pkg::PH_V2DIR: begin
        if (is_dir) begin
          crc_nxt   = 8'd0;
          phase_nxt = mspfp_pkg::PH_V2FLG;
        end else begin
          phase_nxt = mspfp_pkg::PH_IDLE;
        end
      end
      mspfp_pkg::PH_V2FLG: begin
        flags_nxt = in_byte;
        crc_nxt   = crc_step;
        phase_nxt = mspfp_pkg::PH_V2IDL;
      end
      mspfp_pkg::PH_V2IDL: begin
        command_nxt = {8'd0, in_byte};
        crc_nxt     = crc_step;
        phase_nxt   = mspfp_pkg::PH_V2IDH;
      end
      mspfp_pkg::PH_V2IDH: begin
        command_nxt = {in_byte, command_r[7:0]};
        crc_nxt     = crc_step;
        phase_nxt   = mspfp_pkg::PH_V2LENL;
      end
      mspfp_pkg::PH_V2LENL: begin
        inner_len_nxt = {8'd0, in_byte};
        crc_nxt       = crc_step;
        phase_nxt     = mspfp_pkg::PH_V2LENH;
      end
      mspfp_pkg::PH_V2LENH: begin
        inner_len_nxt  = {in_byte, inner_len_r[7:0]};
        crc_nxt        = crc_step;
        byte_index_nxt = 16'd0;
        phase_nxt      = ({in_byte, inner_len_r[7:0]} == 16'd0) ? mspfp_pkg::PH_V2CRC
                                                                : mspfp_pkg::PH_V2PAY;
      end
      mspfp_pkg::PH_V2PAY: begin
        crc_nxt        = crc_step;
        byte_index_nxt = idx_plus1[15:0];
        if (idx_plus1 >= {1'b0, inner_len_r}) phase_nxt = mspfp_pkg::PH_V2CRC;
      end
      mspfp_pkg::PH_V2CRC: begin
        phase_nxt = mspfp_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = mspfp_pkg::PH_IDLE;
      end
    endcase
  end

  // result word for this byte
  always_comb begin
    emit       = 1'b0;
    res_kind   = mspfp_pkg::KIND_DATA;
    res_data   = 8'd0;
    res_status = mspfp_pkg::ST_OK;
    res_ver    = 1'b0;
    res_tun    = 1'b0;
    res_len    = 16'd0;
    case (phase_r)
      mspfp_pkg::PH_V1PAY: begin
        // tunneled: skip inner header (0..4) and inner CRC (last byte)
        if (!tunnel_r || ((byte_index_r > 16'd4) &&
                          (idx_plus1 < {9'd0, outer_size_r}))) begin
          emit     = 1'b1;
          res_data = in_byte;
        end
      end
      mspfp_pkg::PH_V2PAY: begin
        emit     = 1'b1;
        res_data = in_byte;
      end
      mspfp_pkg::PH_V1CHK: begin
        emit     = 1'b1;
        res_kind = mspfp_pkg::KIND_VERDICT;
        if (tunnel_r) begin
          res_ver = 1'b1;
          res_tun = 1'b1;
          res_len = {8'd0, outer_size_r - mspfp_pkg::TUNNEL_HDR_BYTES};
          if (xor_sum_r != in_byte) res_status = mspfp_pkg::ST_V1_CHK_BAD;
          else if (len_bad_r)       res_status = mspfp_pkg::ST_TUN_LEN_BAD;
          else if (crc_r != 8'd0)   res_status = mspfp_pkg::ST_TUN_CRC_BAD;
          else                      res_status = mspfp_pkg::ST_OK;
        end else begin
          res_len    = {8'd0, outer_size_r};
          res_status = (xor_sum_r != in_byte) ? mspfp_pkg::ST_V1_CHK_BAD
                                              : mspfp_pkg::ST_OK;
        end
      end
      mspfp_pkg::PH_V2CRC: begin
        emit       = 1'b1;
        res_kind   = mspfp_pkg::KIND_VERDICT;
        res_ver    = 1'b1;
        res_len    = inner_len_r;
        res_status = (crc_r == in_byte) ? mspfp_pkg::ST_OK : mspfp_pkg::ST_V2_CRC_BAD;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tunnel_cmd_r <= mspfp_pkg::TUNNEL_CMD_RESET;
      phase_r      <= mspfp_pkg::PH_IDLE;
      outer_size_r <= 8'd0;
      byte_index_r <= 16'd0;
      command_r    <= 16'd0;
      flags_r      <= 8'd0;
      inner_len_r  <= 16'd0;
      xor_sum_r    <= 8'd0;
      crc_r        <= 8'd0;
      tunnel_r     <= 1'b0;
      len_bad_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) tunnel_cmd_r <= cfg_data;
      if (in_fire) begin
        phase_r      <= phase_nxt;
        outer_size_r <= outer_size_nxt;
        byte_index_r <= byte_index_nxt;
        command_r    <= command_nxt;
        flags_r      <= flags_nxt;
        inner_len_r  <= inner_len_nxt;
        xor_sum_r    <= xor_sum_nxt;
        crc_r        <= crc_nxt;
        tunnel_r     <= tunnel_nxt;
        len_bad_r    <= len_bad_nxt;
      end
      if (in_ready) out_valid_r <= in_fire && emit;
    end
  end

  // output payload; verdicts carry the frame's id and flags
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_kind_r   <= res_kind;
      out_data_r   <= res_data;
      out_status_r <= res_status;
      out_ver_r    <= res_ver;
      out_tun_r    <= res_tun;
      out_cmd_r    <= (res_kind == mspfp_pkg::KIND_VERDICT) ? command_r : 16'd0;
      out_flags_r  <= (res_kind == mspfp_pkg::KIND_VERDICT) ? flags_r : 8'd0;
      out_len_r    <= res_len;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_data_byte      = out_data_r;
  assign out_status         = out_status_r;
  assign out_frame_version  = out_ver_r;
  assign out_is_tunneled    = out_tun_r;
  assign out_command_id     = out_cmd_r;
  assign out_frame_flags    = out_flags_r;
  assign out_payload_length = out_len_r;

endmodule
